// ===== hw/rtl/trls_pkg.sv =====
// Shared types, constants and helper functions of the timestamp range log store.
`default_nettype none

package trls_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned TIME_W          = 40;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned GRAN_W          = 3;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } trls_op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERWRITE = 2'd1,
    STATUS_FULL      = 2'd2
  } trls_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } trls_state_e;

  typedef struct packed {
    trls_op_e            operation;
    logic [ID_W-1:0]     log_id;
    logic [TIME_W-1:0]   time_a;
    logic [TIME_W-1:0]   time_b;
    logic [GRAN_W-1:0]   granularity;
  } trls_req_t;

  typedef struct packed {
    logic [ID_W-1:0] match_id;
    logic            has_id;
    logic            last_result;
    trls_status_e    status;
  } trls_rsp_t;

  // Keeps the fields from year down to the requested one; codes above
  // second behave as second.
  function automatic logic [TIME_W-1:0] gran_mask(input logic [GRAN_W-1:0] gran);
    logic [4:0] sh;
    case (gran)
      3'd0:    sh = 5'd26;
      3'd1:    sh = 5'd22;
      3'd2:    sh = 5'd17;
      3'd3:    sh = 5'd12;
      3'd4:    sh = 5'd6;
      default: sh = 5'd0;
    endcase
    return {TIME_W{1'b1}} << sh;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trls_mem.sv =====
// Slot memory holding timestamps and ids, one write and one registered read port.
`default_nettype none

module trls_mem #(
  parameter int unsigned TABLE_DEPTH = trls_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [IDX_W-1:0]            wr_addr_i,
  input  wire logic [trls_pkg::TIME_W-1:0] wr_time_i,
  input  wire logic [trls_pkg::ID_W-1:0]   wr_id_i,
  input  wire logic                        rd_en_i,
  input  wire logic [IDX_W-1:0]            rd_addr_i,
  output logic      [trls_pkg::TIME_W-1:0] rd_time_o,
  output logic      [trls_pkg::ID_W-1:0]   rd_id_o
);

  logic [trls_pkg::TIME_W-1:0] time_mem [TABLE_DEPTH];
  logic [trls_pkg::ID_W-1:0]   id_mem   [TABLE_DEPTH];
  logic [trls_pkg::TIME_W-1:0] rd_time_q;
  logic [trls_pkg::ID_W-1:0]   rd_id_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i] <= wr_time_i;
      id_mem[wr_addr_i]   <= wr_id_i;
    end
  end

  // Read data holds while the sequencer is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_time_q <= time_mem[rd_addr_i];
      rd_id_q   <= id_mem[rd_addr_i];
    end
  end

  assign rd_time_o = rd_time_q;
  assign rd_id_o   = rd_id_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trls_cmp.sv =====
// Shared slot comparator: exact match for a put, masked range test for a retrieve.
`default_nettype none

module trls_cmp (
  input  wire trls_pkg::trls_op_e          op_i,
  input  wire logic [trls_pkg::TIME_W-1:0] mask_i,
  input  wire logic [trls_pkg::TIME_W-1:0] key_i,
  input  wire logic [trls_pkg::TIME_W-1:0] lo_i,
  input  wire logic [trls_pkg::TIME_W-1:0] hi_i,
  input  wire logic [trls_pkg::TIME_W-1:0] slot_time_i,
  output logic                             hit_o
);

  logic [trls_pkg::TIME_W-1:0] masked;

  assign masked = slot_time_i & mask_i;

  always_comb begin
    case (op_i)
      trls_pkg::OP_PUT: hit_o = (slot_time_i == key_i);
      trls_pkg::OP_GET: hit_o = (masked >= lo_i) && (masked <= hi_i);
      default:          hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/timestamp_range_log_store.sv =====
// Top level of the timestamp range log store: sequencer, output register, checks.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------------
//   request | in        | req_valid_i/req_ready_o | req_i (trls_req_t)
//   result  | out       | rsp_valid_o/rsp_ready_i | rsp_o (trls_rsp_t)
//
// A request is latched in the idle state, then the occupied slots are read one by one
// through the single comparator, and the finish state writes back and posts the
// final result. A put that finds its timestamp stops scanning there.
// Occupied slots are always 0..fill-1, so the fill count stands in for per-slot
// valid bits. The memory needs no clearing after reset. A full output register
// stalls a retrieve's scan at its second and later matches, and holds the final result.
`default_nettype none

module timestamp_range_log_store #(
  parameter int unsigned TABLE_DEPTH = trls_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire trls_pkg::trls_req_t req_i,
  output logic                     rsp_valid_o,
  input  wire logic                rsp_ready_i,
  output trls_pkg::trls_rsp_t      rsp_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  trls_pkg::trls_state_e       state_q, state_d;
  trls_pkg::trls_op_e          op_q, op_d;
  logic [trls_pkg::ID_W-1:0]   id_q, id_d;
  logic [trls_pkg::TIME_W-1:0] key_q, key_d;
  logic [trls_pkg::TIME_W-1:0] mask_q, mask_d;
  logic [trls_pkg::TIME_W-1:0] lo_q, lo_d;
  logic [trls_pkg::TIME_W-1:0] hi_q, hi_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic                        hit_q, hit_d;
  logic [IDX_W-1:0]            hit_idx_q, hit_idx_d;
  logic                        held_q, held_d;
  logic [trls_pkg::ID_W-1:0]   held_id_q, held_id_d;
  logic                        out_valid_q, out_valid_d;
  trls_pkg::trls_rsp_t         out_q, out_d;

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [trls_pkg::TIME_W-1:0] rd_time;
  logic [trls_pkg::ID_W-1:0]   rd_id;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic                        hit;
  logic                        last_slot;
  logic                        out_free;
  logic                        push;
  trls_pkg::trls_rsp_t         push_data;
  logic [trls_pkg::TIME_W-1:0] req_mask;

  trls_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_time_i(key_q),
    .wr_id_i  (id_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_time_o(rd_time),
    .rd_id_o  (rd_id)
  );

  trls_cmp u_cmp (
    .op_i       (op_q),
    .mask_i     (mask_q),
    .key_i      (key_q),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .slot_time_i(rd_time),
    .hit_o      (hit)
  );

  assign req_mask    = trls_pkg::gran_mask(req_i.granularity);
  assign last_slot   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == trls_pkg::S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    key_d     = key_q;
    mask_d    = mask_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    held_d    = held_q;
    held_id_d = held_id_q;
    rd_en     = 1'b0;
    rd_addr   = IDX_W'(idx_q + IDX_W'(1));
    wr_en     = 1'b0;
    wr_addr   = fill_q[IDX_W-1:0];
    push      = 1'b0;
    push_data = '{match_id: '0, has_id: 1'b0, last_result: 1'b1,
                  status: trls_pkg::STATUS_OK};

    case (state_q)
      trls_pkg::S_IDLE: begin
        if (req_valid_i) begin
          op_d   = req_i.operation;
          id_d   = req_i.log_id;
          key_d  = req_i.time_a;
          mask_d = req_mask;
          lo_d   = req_i.time_a & req_mask;
          hi_d   = req_i.time_b & req_mask;
          idx_d  = '0;
          hit_d  = 1'b0;
          held_d = 1'b0;
          if (fill_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = trls_pkg::S_SCAN;
          end else begin
            state_d = trls_pkg::S_FINISH;
          end
        end
      end

      trls_pkg::S_SCAN: begin
        if (op_q == trls_pkg::OP_PUT) begin
          if (hit) begin
            hit_d     = 1'b1;
            hit_idx_d = idx_q;
            state_d   = trls_pkg::S_FINISH;
          end else if (last_slot) begin
            state_d = trls_pkg::S_FINISH;
          end else begin
            idx_d = IDX_W'(idx_q + IDX_W'(1));
            rd_en = 1'b1;
          end
        end else if (!(hit && held_q && !out_free)) begin
          // Each match is held back until the next match or the end of the scan, so the final one can carry last.
          if (hit) begin
            held_d    = 1'b1;
            held_id_d = rd_id;
            if (held_q) begin
              push      = 1'b1;
              push_data = '{match_id: held_id_q, has_id: 1'b1, last_result: 1'b0,
                            status: trls_pkg::STATUS_OK};
            end
          end
          if (last_slot) begin
            state_d = trls_pkg::S_FINISH;
          end else begin
            idx_d = IDX_W'(idx_q + IDX_W'(1));
            rd_en = 1'b1;
          end
        end
      end

      trls_pkg::S_FINISH: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = trls_pkg::S_IDLE;
          if (op_q == trls_pkg::OP_PUT) begin
            if (hit_q) begin
              wr_en            = 1'b1;
              wr_addr          = hit_idx_q;
              push_data.status = trls_pkg::STATUS_OVERWRITE;
            end else if (fill_q == CNT_W'(TABLE_DEPTH)) begin
              push_data.status = trls_pkg::STATUS_FULL;
            end else begin
              wr_en  = 1'b1;
              fill_d = fill_q + CNT_W'(1);
            end
          end else if (held_q) begin
            push_data = '{match_id: held_id_q, has_id: 1'b1, last_result: 1'b1,
                          status: trls_pkg::STATUS_OK};
          end
        end
      end

      default: begin
        state_d = trls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trls_pkg::S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      held_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    key_q     <= key_d;
    mask_q    <= mask_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    idx_q     <= idx_d;
    hit_idx_q <= hit_idx_d;
    held_id_q <= held_id_d;
    out_q     <= out_d;
  end

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> out_free)
    else $error("result pushed into an occupied output register");

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q != trls_pkg::S_IDLE))
    else $error("accepted request did not start");

  // Every request ends with exactly one final result on its way back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trls_pkg::S_FINISH && state_d == trls_pkg::S_IDLE)
      |=> (rsp_valid_o && rsp_o.last_result))
    else $error("request finished without a final result");

endmodule

`default_nettype wire
